// ===== sv/csch_pkg.sv =====
`default_nettype none

package csch_pkg;

    localparam int ID_W = 6;

    typedef enum logic [1:0] {
        MODE_ADD      = 2'd0,
        MODE_REMOVE   = 2'd1,
        MODE_SCHEDULE = 2'd2,
        MODE_YIELD    = 2'd3
    } csch_mode_t;

    typedef struct packed {
        csch_mode_t        mode;
        logic [ID_W-1:0]   task_id;
    } csch_cmd_t;

    typedef struct packed {
        logic [ID_W-1:0]   selected_id;
        logic              selected_valid;
        logic              set_empty;
        logic              bad_id;
        logic              reschedule;
    } csch_result_t;

endpackage

`default_nettype wire

// ===== sv/csch_hi_enc.sv =====
`default_nettype none

// index of the highest set bit
module csch_hi_enc #(
    parameter int WIDTH = 64
) (
    input  wire logic [WIDTH-1:0]              vec,
    output logic      [csch_pkg::ID_W-1:0]     idx
);

    always_comb
    begin
        idx = '0;
        for (int i = 0; i < WIDTH; i++)
        begin
            if (vec[i])
            begin
                idx = csch_pkg::ID_W'(i);
            end
        end
    end

endmodule

`default_nettype wire

// ===== sv/csch_core.sv =====
`default_nettype none

module csch_core #(
    parameter int MAX_TASKS = 64
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cmd_valid,
    input  wire csch_pkg::csch_cmd_t    cmd,
    output logic                        done,
    output csch_pkg::csch_result_t      result
);

    localparam int IDC_W = csch_pkg::ID_W + 1;

    logic [MAX_TASKS-1:0]          map_reg, map_next;
    logic [csch_pkg::ID_W-1:0]     cur_id_reg, cur_id_next;
    logic                          cur_valid_reg, cur_valid_next;
    logic                          done_reg;
    csch_pkg::csch_result_t        result_reg, result_next;

    logic [MAX_TASKS-1:0]          id_sel, cur_sel, below, new_map, new_map_rev;
    logic                          id_ok, id_present, multi;
    logic [csch_pkg::ID_W-1:0]     below_hi, map_hi, rev_hi, new_lo;
    logic                          below_any, new_any;
    logic [csch_pkg::ID_W-1:0]     id_upd;
    logic                          valid_upd, bad, resched;

    assign id_sel     = {{(MAX_TASKS-1){1'b0}}, 1'b1} << cmd.task_id;
    assign cur_sel    = {{(MAX_TASKS-1){1'b0}}, 1'b1} << cur_id_reg;
    assign id_ok      = {1'b0, cmd.task_id} < IDC_W'(MAX_TASKS);
    assign id_present = id_ok && (|(map_reg & id_sel));
    assign below      = map_reg & (cur_sel - {{(MAX_TASKS-1){1'b0}}, 1'b1});
    assign multi      = |(map_reg & (map_reg - {{(MAX_TASKS-1){1'b0}}, 1'b1}));
    assign below_any  = |below;

    csch_hi_enc #(.WIDTH(MAX_TASKS)) u_below_enc (
        .vec (below),
        .idx (below_hi)
    );

    csch_hi_enc #(.WIDTH(MAX_TASKS)) u_map_enc (
        .vec (map_reg),
        .idx (map_hi)
    );

    always_comb
    begin
        map_next  = map_reg;
        id_upd    = cur_id_reg;
        valid_upd = cur_valid_reg;
        bad       = 1'b0;
        resched   = 1'b0;
        unique case (cmd.mode)
            csch_pkg::MODE_ADD:
            begin
                if (id_ok)
                begin
                    map_next = map_reg | id_sel;
                end
            end
            csch_pkg::MODE_REMOVE:
            begin
                if (id_ok)
                begin
                    map_next = map_reg & ~id_sel;
                    if (cur_valid_reg && (cur_id_reg == cmd.task_id))
                    begin
                        valid_upd = 1'b0;
                    end
                end
            end
            csch_pkg::MODE_SCHEDULE:
            begin
                if (id_present)
                begin
                    id_upd    = cmd.task_id;
                    valid_upd = 1'b1;
                    resched   = 1'b1;
                end
                else
                begin
                    bad = 1'b1;
                end
            end
            csch_pkg::MODE_YIELD:
            begin
                if (multi)
                begin
                    id_upd    = (cur_valid_reg && below_any) ? below_hi : map_hi;
                    valid_upd = 1'b1;
                    resched   = 1'b1;
                end
            end
        endcase
    end

    assign new_map = map_next;
    assign new_any = |new_map;

    always_comb
    begin
        for (int i = 0; i < MAX_TASKS; i++)
        begin
            new_map_rev[i] = new_map[MAX_TASKS-1-i];
        end
    end

    csch_hi_enc #(.WIDTH(MAX_TASKS)) u_low_enc (
        .vec (new_map_rev),
        .idx (rev_hi)
    );

    assign new_lo = csch_pkg::ID_W'(MAX_TASKS - 1) - rev_hi;

    // fix-up: pick the lowest present id when nothing is current
    always_comb
    begin
        cur_id_next    = id_upd;
        cur_valid_next = valid_upd;
        if (!valid_upd && new_any)
        begin
            cur_id_next    = new_lo;
            cur_valid_next = 1'b1;
        end
        result_next.selected_id    = cur_valid_next ? cur_id_next : '0;
        result_next.selected_valid = cur_valid_next;
        result_next.set_empty      = !new_any;
        result_next.bad_id         = bad;
        result_next.reschedule     = resched;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            map_reg       <= '0;
            cur_id_reg    <= '0;
            cur_valid_reg <= 1'b0;
            done_reg      <= 1'b0;
        end
        else
        begin
            done_reg <= cmd_valid;
            if (cmd_valid)
            begin
                map_reg       <= map_next;
                cur_id_reg    <= cur_id_next;
                cur_valid_reg <= cur_valid_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_valid)
        begin
            result_reg <= result_next;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

    a_cur_present: assert property (@(posedge clk) disable iff (!rst_n)
        cur_valid_reg |-> (|(map_reg & cur_sel)))
        else $error("current id not present");

    a_valid_iff_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        cur_valid_reg == (|map_reg))
        else $error("current valid disagrees with map");

    a_result_flags: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.selected_valid != result.set_empty))
        else $error("selection and empty flag disagree");

    a_bad_no_resched: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.bad_id |-> !result.reschedule)
        else $error("bad id with reschedule");

    a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid |=> done)
        else $error("transaction without result");

endmodule

`default_nettype wire

// ===== sv/cooperative_state_scheduler.sv =====
`default_nettype none

// Cooperative scheduler: a presence bitmap of task ids with one current id.
// busy is always low, so a transaction can be issued every cycle. Each
// transaction yields one result, registered first in the input register
// and then, after one pass through the bitmap update and priority encoders,
// in the result register; it is shown for exactly one cycle with done high.
// The receiver cannot stall results; it must take each one when done is high.
// Ids at or above MAX_TASKS are ignored by add/remove and are absent for
// schedule.
module cooperative_state_scheduler #(
    parameter int MAX_TASKS = 64
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   start,
    output logic                        busy,
    input  wire csch_pkg::csch_cmd_t    cmd,
    output logic                        done,
    output csch_pkg::csch_result_t      result
);

    logic                   cmd_valid_reg;
    csch_pkg::csch_cmd_t    cmd_reg;

    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_valid_reg <= 1'b0;
            cmd_reg       <= '0;
        end
        else
        begin
            cmd_valid_reg <= start && !busy;
            if (start && !busy)
            begin
                cmd_reg <= cmd;
            end
        end
    end

    csch_core #(.MAX_TASKS(MAX_TASKS)) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid_reg),
        .cmd       (cmd_reg),
        .done      (done),
        .result    (result)
    );

endmodule

`default_nettype wire
